/* rtl/core/crank_period_to_rpm_assert.svh */
// Assertion macros shared by the crank_period_to_rpm RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CRANK_PERIOD_TO_RPM_ASSERT_SVH
`define CRANK_PERIOD_TO_RPM_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CPTR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crank_period_to_rpm: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define CPTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crank_period_to_rpm: next-cycle check failed");

`endif

/* rtl/core/cptr_pkg.sv */
// Package for the crank period to rpm block: widths, codes, reset values,
// controller states and the controller/datapath command and status types.
`default_nettype none
package cptr_pkg;

    localparam int CFG_W  = 20;               // configuration register width
    localparam int NUM_W  = 20;               // dividend (rpm numerator) width
    localparam int DIV_W  = 21;               // divisor width (age inside window)
    localparam int RPM_W  = 21;               // reported rpm width, signed
    localparam int IDX_W  = 8;                // event index width
    localparam int CNT_W  = $clog2(NUM_W);    // divider step counter width

    localparam int RESET_TPS         = 1000;
    localparam int RESET_NUM         = 30000;
    localparam int TIME_BACK_SECONDS = 10;

    // Register indexes (paddr bit 2).
    localparam logic REG_TPS = 1'b0;
    localparam logic REG_NUM = 1'b1;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DIV_DONE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic load_neg_one;
        logic load_quot;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_evt0;
        logic in_window;
        logic age_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/core/cptr_regs.sv */
// Configuration registers of the crank period to rpm block, APB-style port.
// Depends on cptr_pkg.
`default_nettype none
module cptr_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [cptr_pkg::CFG_W-1:0] o_tps,
    output logic      [cptr_pkg::CFG_W-1:0] o_num
);
    import cptr_pkg::*;

    logic [CFG_W-1:0] r_tps;
    logic [CFG_W-1:0] r_num;
    logic             w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= CFG_W'(RESET_TPS);
            r_num <= CFG_W'(RESET_NUM);
        end else if (w_write) begin
            case (paddr[2])
                REG_TPS: r_tps <= pwdata[CFG_W-1:0];
                REG_NUM: r_num <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TPS: prdata = 32'(r_tps);
            REG_NUM: prdata = 32'(r_num);
            default: prdata = '0;
        endcase
    end

    assign o_tps = r_tps;
    assign o_num = r_num;

endmodule
`default_nettype wire

/* rtl/core/cptr_ctrl.sv */
// Controller state machine of the crank period to rpm block.
// Depends on cptr_pkg and crank_period_to_rpm_assert.svh.
`default_nettype none
`include "crank_period_to_rpm_assert.svh"
module cptr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire cptr_pkg::t_dp_status i_status,
    output cptr_pkg::t_dp_cmd         o_cmd
);
    import cptr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.is_evt0 && i_status.in_window && !i_status.age_zero) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_DIV_DONE;
            end
            ST_DIV_DONE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_CHECK: begin
                if (i_status.is_evt0 && i_status.in_window) begin
                    o_cmd.load_neg_one = i_status.age_zero;
                    o_cmd.div_start    = !i_status.age_zero;
                end
            end
            ST_DIV:      o_cmd.div_step  = 1'b1;
            ST_DIV_DONE: o_cmd.load_quot = 1'b1;
            ST_EMIT:     o_cmd.emit      = i_status.out_free;
            default: ;
        endcase
    end

    `CPTR_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, (r_state == ST_DIV) && i_status.div_last, r_state == ST_DIV_DONE)
    `CPTR_ASSERT_SAME(a_div_only_evt0, i_clk, i_rst_n, r_state == ST_DIV, i_status.is_evt0 && i_status.in_window)
    `CPTR_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n, o_cmd.accept, (r_state == ST_CHECK) && o_in_stall)
    `CPTR_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_status.out_free && (r_state == ST_EMIT))

endmodule
`default_nettype wire

/* rtl/core/cptr_datapath.sv */
// Datapath of the crank period to rpm block: time and event registers,
// window compares, serial restoring divider and the output register.
// Depends on cptr_pkg.
`default_nettype none
module cptr_datapath #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cptr_pkg::t_dp_cmd                 i_cmd,
    output cptr_pkg::t_dp_status                   o_status,
    input  wire logic                              i_command,
    input  wire logic [cptr_pkg::IDX_W-1:0]        i_event_index,
    input  wire logic [cptr_pkg::CFG_W-1:0]        i_tps,
    input  wire logic [cptr_pkg::CFG_W-1:0]        i_num,
    output logic signed [cptr_pkg::RPM_W-1:0]      o_reported_rpm,
    output logic                                   o_running,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall
);
    import cptr_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > DIV_W) ? TIME_WIDTH : DIV_W;
    localparam logic [TIME_WIDTH-1:0] L_LAST_RESET =
        TIME_WIDTH'(0) - TIME_WIDTH'(TIME_BACK_SECONDS * RESET_TPS);

    logic [TIME_WIDTH-1:0]   r_time;
    logic [TIME_WIDTH-1:0]   r_last;
    logic [TIME_WIDTH-1:0]   r_age;
    logic signed [RPM_W-1:0] r_rpm;
    logic                    r_is_evt0;
    logic [DIV_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_quot;
    logic [CNT_W-1:0]        r_div_cnt;
    logic signed [RPM_W-1:0] r_out_rpm;
    logic                    r_out_running;
    logic                    r_out_valid;

    logic [TIME_WIDTH-1:0]   w_age_now;
    logic [CMP_W-1:0]        w_age_ext;
    logic [CMP_W-1:0]        w_age_now_ext;
    logic [CMP_W-1:0]        w_win_run;
    logic [CMP_W-1:0]        w_win_stop;
    logic [DIV_W-1:0]        w_divisor;
    logic [DIV_W:0]          w_rem_sh;
    logic [DIV_W:0]          w_diff;

    // Age of the stored event at emit time, and the two windows.
    assign w_age_now     = r_time - r_last;
    assign w_age_ext     = CMP_W'(r_age);
    assign w_age_now_ext = CMP_W'(w_age_now);
    assign w_win_run     = CMP_W'({i_tps, 1'b0});
    assign w_win_stop    = CMP_W'(i_tps);

    // Divisor is the period; it lies inside the running window when used.
    assign w_divisor = w_age_ext[DIV_W-1:0];
    assign w_rem_sh  = {r_rem, r_quot[NUM_W-1]};
    assign w_diff    = w_rem_sh - {1'b0, w_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_last      <= L_LAST_RESET;
            r_rpm       <= '0;
            r_is_evt0   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_is_evt0 <= (i_command == CMD_EVENT) && (i_event_index == '0);
                if (i_command == CMD_TICK) begin
                    r_time <= r_time + TIME_WIDTH'(1);
                end else if (i_event_index == '0) begin
                    r_last <= r_time;
                end
            end
            if (i_cmd.load_neg_one) r_rpm <= '1;
            if (i_cmd.load_quot)    r_rpm <= $signed({1'b0, r_quot});
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: period capture, divider and output data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_age <= r_time - r_last;
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quot    <= i_num;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + CNT_W'(1);
            if (!w_diff[DIV_W]) begin
                r_rem  <= w_diff[DIV_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[DIV_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out_running <= w_age_now_ext < w_win_run;
            r_out_rpm     <= (w_age_now_ext > w_win_stop) ? '0 : r_rpm;
        end
    end

    assign o_status.is_evt0   = r_is_evt0;
    assign o_status.in_window = w_age_ext < w_win_run;
    assign o_status.age_zero  = (r_age == '0);
    assign o_status.div_last  = (r_div_cnt == CNT_W'(NUM_W - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_reported_rpm = r_out_rpm;
    assign o_running      = r_out_running;
    assign o_out_valid    = r_out_valid;

endmodule
`default_nettype wire

/* rtl/core/crank_period_to_rpm.sv */
// Steps: a tick, an ignored event, or a counted event outside the running window or with zero
// period goes through check, then emit, once accepted; a counted event with a nonzero period
// inside the running window goes through check, the 20-step serial restoring divider, a
// quotient load and then emit. A new request is taken only once the current one is emitted;
// a full output register adds wait. Reset is synchronous and active low; it clears the control
// state, time, rpm and valid flag at once, with no clearing pass (payload registers are not
// reset), and places the stored event time ten default seconds in the past.
`default_nettype none
module crank_period_to_rpm #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request channel: one timer tick or one shaft event per request.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_command,
    input  wire logic [cptr_pkg::IDX_W-1:0]         i_event_index,
    // Result channel: one result per request.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [cptr_pkg::RPM_W-1:0]       o_reported_rpm,
    output logic                                    o_running,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready
);
    import cptr_pkg::*;

    // The controller sequences each request: it takes one request in idle, lets the
    // datapath judge whether the stored event lies inside the running window, runs the
    // divider for a counted event with a nonzero period inside that window, and then waits
    // until the output register is free to load the result. The output register lets a
    // finished result wait while the next request is already taken in and worked on.

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [CFG_W-1:0] w_tps;
    logic [CFG_W-1:0] w_num;

    // Register file: ticks per second at address 0, rpm numerator at address 4.
    cptr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tps   (w_tps),
        .o_num   (w_num)
    );

    cptr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the wrapping time counter, the stored event time and the rpm.
    // All ages are modular differences within TIME_WIDTH bits.
    cptr_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_command      (i_command),
        .i_event_index  (i_event_index),
        .i_tps          (w_tps),
        .i_num          (w_num),
        .o_reported_rpm (o_reported_rpm),
        .o_running      (o_running),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall)
    );

endmodule
`default_nettype wire
